>>> src/ndef_record_stream_parser_top_assert.svh
// assertion macros for the ndef record stream parser checker
// depends on a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef NDEF_RECORD_STREAM_PARSER_TOP_ASSERT_SVH
`define NDEF_RECORD_STREAM_PARSER_TOP_ASSERT_SVH

// implication checked outside reset
`define NDRSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define NDRSP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication checked at every edge, reset included
`define NDRSP_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ndrsp_pkg.sv
// shared types and constants for the ndef record stream parser
// no dependencies
package ndrsp_pkg;

    localparam logic [2:0] K_FLAGS = 3'd0;
    localparam logic [2:0] K_TLEN  = 3'd1;
    localparam logic [2:0] K_PLEN  = 3'd2;
    localparam logic [2:0] K_ILEN  = 3'd3;
    localparam logic [2:0] K_TYPE  = 3'd4;
    localparam logic [2:0] K_PAY   = 3'd5;
    localparam logic [2:0] K_ID    = 3'd6;

    localparam int FLAG_SR_BIT = 4;
    localparam int FLAG_IL_BIT = 3;

    localparam logic [1:0] LEN_LAST_BYTE = 2'd3;

    localparam int TDATA_W = 64;
    localparam int TUSER_W = 4;

    typedef struct packed {
        logic [7:0]  id_length;
        logic [31:0] payload_length;
        logic [7:0]  type_length;
        logic [7:0]  header_flags;
        logic        truncated;
        logic        record_done;
        logic [2:0]  field_kind;
        logic [7:0]  byte_out;
    } t_result;

endpackage

>>> src/ndrsp_parse.sv
// input register, record state and per-byte field decode
// depends on ndrsp_pkg
module ndrsp_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  logic              i_room,
    output logic              o_push,
    output ndrsp_pkg::t_result o_res
);
    import ndrsp_pkg::*;

    typedef struct packed {
        logic [2:0]  phase;
        logic [31:0] left;
        logic        done;
    } t_enter;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    logic [2:0]  r_phase;
    logic [7:0]  r_flags;
    logic [7:0]  r_tlen;
    logic [31:0] r_plen;
    logic [7:0]  r_ilen;
    logic [31:0] r_left;
    logic [1:0]  r_cnt;

    logic [2:0]  n_phase;
    logic [7:0]  n_flags;
    logic [7:0]  n_tlen;
    logic [31:0] n_plen;
    logic [7:0]  n_ilen;
    logic [31:0] n_left;
    logic [1:0]  n_cnt;

    logic [2:0]  kind;
    logic        done;
    logic        trunc;
    logic        hdr_end;
    logic        fire;
    logic [31:0] left_dec;
    t_enter      ent;

    // first non-empty data field at or after kind from
    function automatic t_enter enter_data(input logic [2:0] from, input logic [7:0] tlen,
                                          input logic [31:0] plen, input logic [7:0] ilen);
        t_enter e;
        e.phase = K_FLAGS;
        e.left  = '0;
        e.done  = 1'b1;
        if (from <= K_TYPE && tlen != 8'd0) begin
            e.phase = K_TYPE;
            e.left  = {24'd0, tlen};
            e.done  = 1'b0;
        end else if (from <= K_PAY && plen != 32'd0) begin
            e.phase = K_PAY;
            e.left  = plen;
            e.done  = 1'b0;
        end else if (from <= K_ID && ilen != 8'd0) begin
            e.phase = K_ID;
            e.left  = {24'd0, ilen};
            e.done  = 1'b0;
        end
        return e;
    endfunction

    assign o_ready = !r_in_valid || i_room;
    assign fire    = r_in_valid && i_room;
    assign kind    = (r_phase > K_ID) ? K_FLAGS : r_phase;
    assign left_dec = (r_left != 32'd0) ? r_left - 32'd1 : r_left;

    always_comb begin
        n_phase = r_phase;
        n_flags = r_flags;
        n_tlen  = r_tlen;
        n_plen  = r_plen;
        n_ilen  = r_ilen;
        n_left  = r_left;
        n_cnt   = r_cnt;
        done    = 1'b0;
        hdr_end = 1'b0;
        ent     = '0;
        case (kind)
            K_FLAGS: begin
                n_flags = r_in_byte;
                n_tlen  = '0;
                n_plen  = '0;
                n_ilen  = '0;
                n_left  = '0;
                n_cnt   = '0;
                n_phase = K_TLEN;
            end
            K_TLEN: begin
                n_tlen  = r_in_byte;
                n_cnt   = '0;
                n_phase = K_PLEN;
            end
            K_PLEN: begin
                if (r_flags[FLAG_SR_BIT]) begin
                    n_plen  = {24'd0, r_in_byte};
                    hdr_end = 1'b1;
                end else begin
                    // big-endian: first length byte lands in the top byte
                    n_plen = r_plen | ({24'd0, r_in_byte} << {~r_cnt, 3'b000});
                    if (r_cnt == LEN_LAST_BYTE) begin
                        hdr_end = 1'b1;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + 2'd1;
                    end
                end
                if (hdr_end) begin
                    if (r_flags[FLAG_IL_BIT]) begin
                        n_phase = K_ILEN;
                    end else begin
                        ent     = enter_data(K_TYPE, n_tlen, n_plen, n_ilen);
                        n_phase = ent.phase;
                        n_left  = ent.left;
                        done    = ent.done;
                    end
                end
            end
            K_ILEN: begin
                n_ilen  = r_in_byte;
                ent     = enter_data(K_TYPE, n_tlen, n_plen, r_in_byte);
                n_phase = ent.phase;
                n_left  = ent.left;
                done    = ent.done;
            end
            default: begin
                n_left = left_dec;
                if (left_dec == 32'd0) begin
                    ent     = enter_data(3'(kind + 3'd1), n_tlen, n_plen, n_ilen);
                    n_phase = ent.phase;
                    n_left  = ent.left;
                    done    = ent.done;
                end
            end
        endcase
        trunc = r_in_last && !done;
        if (done || trunc) begin
            n_phase = K_FLAGS;
            n_left  = '0;
            n_cnt   = '0;
        end
    end

    assign o_push               = fire;
    assign o_res.byte_out       = r_in_byte;
    assign o_res.field_kind     = kind;
    assign o_res.record_done    = done;
    assign o_res.truncated      = trunc;
    assign o_res.header_flags   = n_flags;
    assign o_res.type_length    = n_tlen;
    assign o_res.payload_length = n_plen;
    assign o_res.id_length      = n_ilen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
            r_in_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= K_FLAGS;
            r_flags <= '0;
            r_tlen  <= '0;
            r_plen  <= '0;
            r_ilen  <= '0;
            r_left  <= '0;
            r_cnt   <= '0;
        end else if (fire) begin
            r_phase <= n_phase;
            r_flags <= n_flags;
            r_tlen  <= n_tlen;
            r_plen  <= n_plen;
            r_ilen  <= n_ilen;
            r_left  <= n_left;
            r_cnt   <= n_cnt;
        end
    end

endmodule

>>> src/ndrsp_out_buf.sv
// result register with skid stage toward the output stream
// depends on ndrsp_pkg
module ndrsp_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ndrsp_pkg::t_result i_res,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_ready,
    output ndrsp_pkg::t_result o_res
);
    import ndrsp_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    pop;
    logic    take_out;

    assign o_room   = !r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_res    = r_out;
    assign pop      = r_out_valid && i_ready;
    assign take_out = !r_out_valid || pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (take_out) begin
            r_out_valid  <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_out) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

endmodule

>>> src/ndef_record_stream_parser_top.sv
// ndef record stream parser: tags each message byte with its record field
// a byte is held in the input register, then its result in the output or skid register
// throughput: one byte per cycle while the output stream is not stalled
// reset: synchronous active-low i_rst_n clears the record state and all valid flags
// depends on ndrsp_pkg, ndrsp_parse, ndrsp_out_buf
module ndef_record_stream_parser_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,  // data_byte
    input  logic                          i_s_axis_tlast,  // last_byte
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // byte_out, header_flags, type_length, payload_length, id_length
    output logic [ndrsp_pkg::TDATA_W-1:0] o_m_axis_tdata,
    output logic [ndrsp_pkg::TUSER_W-1:0] o_m_axis_tuser,  // field_kind, truncated
    output logic                          o_m_axis_tlast   // record_done
);
    import ndrsp_pkg::*;

    logic    push;
    logic    room;
    t_result res_in;
    t_result res_out;

    ndrsp_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .i_room  (room),
        .o_push  (push),
        .o_res   (res_in)
    );

    ndrsp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_res   (res_in),
        .o_room  (room),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (res_out)
    );

    assign o_m_axis_tdata = {res_out.id_length, res_out.payload_length, res_out.type_length,
                             res_out.header_flags, res_out.byte_out};
    assign o_m_axis_tuser = {res_out.truncated, res_out.field_kind};
    assign o_m_axis_tlast = res_out.record_done;

endmodule

>>> src/ndrsp_checker.sv
// port-level checks for the ndef record stream parser, bound to the top level
// depends on ndef_record_stream_parser_top_assert.svh and ndrsp_pkg
`include "ndef_record_stream_parser_top_assert.svh"

module ndrsp_port_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_s_axis_tready,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [ndrsp_pkg::TDATA_W-1:0] o_m_axis_tdata,
    input logic [ndrsp_pkg::TUSER_W-1:0] o_m_axis_tuser,
    input logic                          o_m_axis_tlast
);
    import ndrsp_pkg::*;

    logic stall;
    logic flags_byte;

    assign stall      = o_m_axis_tvalid && !i_m_axis_tready;
    assign flags_byte = o_m_axis_tvalid && (o_m_axis_tuser[2:0] == K_FLAGS);

    `NDRSP_ASSERT_NXT(a_stall_hold, stall,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
        && $stable(o_m_axis_tlast), "output transaction changed while stalled")

    `NDRSP_ASSERT_IMP(a_done_not_trunc, o_m_axis_tvalid,
        !(o_m_axis_tlast && o_m_axis_tuser[3]), "record both completed and truncated")

    `NDRSP_ASSERT_IMP(a_flags_clears, flags_byte,
        o_m_axis_tdata[23:16] == 8'd0 && o_m_axis_tdata[55:24] == 32'd0
        && o_m_axis_tdata[63:56] == 8'd0, "flags byte did not clear held lengths")

    `NDRSP_ASSERT_IMP(a_backpressure_cause, !o_s_axis_tready, o_m_axis_tvalid,
        "input stalled with no output pending")

    `NDRSP_ASSERT_RST(a_reset_idle, !i_rst_n, !o_m_axis_tvalid,
        "output valid right after reset")

endmodule

bind ndef_record_stream_parser_top ndrsp_port_checker u_ndrsp_checker (.*);
